[sv/rln_pkg.sv]
package rln_pkg;

    localparam int ROW_CAPACITY = 64;
    localparam int CNT_W        = $clog2(ROW_CAPACITY + 1);
    localparam int ADDR_W       = $clog2(ROW_CAPACITY);
    localparam int DATA_W       = 16;
    localparam int RAM_W        = 3 * DATA_W;

    // row sum and centred element d = n*x - sum
    localparam int SUM_W  = DATA_W + CNT_W;
    localparam int D_W    = SUM_W + 1;
    localparam int SQP_W  = 2 * D_W;
    localparam int SQ_W   = 2 * (D_W - 2) + CNT_W;
    localparam int N3_W   = 3 * CNT_W;

    // variance, root and divider
    localparam int EPS_W    = 16;
    localparam int V_W      = 32;
    localparam int V_SHIFT  = 30;
    localparam int OP_W     = V_W + V_SHIFT;
    localparam int R_W      = OP_W / 2;
    localparam int DEN_W    = CNT_W + R_W;
    localparam int XH_SHIFT = 31;
    localparam int NUM_W    = D_W - 2 + XH_SHIFT + 1;
    localparam int Q_W      = 32;

    // output arithmetic
    localparam int XH_W    = 24;
    localparam int PROD_W  = DATA_W + XH_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int FRAC_W  = 16;
    localparam int Y_W     = ACC_W - FRAC_W;
    localparam int Y_MAX   = 32767;
    localparam int Y_MIN   = -32768;
    localparam int ROUND_HALF = 32768;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
    localparam int DRAIN_CYCLES = 3;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] scale;
        logic signed [DATA_W-1:0] shift;
        logic                     row_end;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] normalized;
        logic                     saturated;
        logic                     truncated;
        logic                     final_res;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SSQ,
        ST_DRAIN,
        ST_VSTART,
        ST_VWAIT,
        ST_SQSTART,
        ST_SQWAIT,
        ST_DEN,
        ST_E_RD,
        ST_E_D,
        ST_E_DIV,
        ST_E_WAIT,
        ST_E_MUL,
        ST_E_OUT
    } state_t;

    typedef struct packed {
        logic              load;
        logic              ss_rd;
        logic              el_rd;
        logic [ADDR_W-1:0] rd_addr;
        logic              acc_clr;
        logic              vdiv_start;
        logic              v_load;
        logic              sqrt_start;
        logic              den_load;
        logic              d_load;
        logic              ediv_start;
        logic              prod_load;
        logic              out_load;
        logic              last;
        logic              row_clr;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             div_busy;
        logic             div_done;
        logic             sqrt_done;
        logic             out_free;
    } sts_t;

endpackage

[sv/row_layer_normalizer.sv]
// row layer normalisation, one row element per input word
// input channel s_*: sample, scale and shift in signed Q8.8 plus row_end.
// words are stored until row_end; up to ROW_CAPACITY are kept, later ones
// are dropped and every result of that row carries truncated.
// at row end the block sums (n*x - sum)^2 over the row, divides for the
// variance, takes the square root of var + epsilon and forms n*root, then
// emits one result word per stored element on m_*, in arrival order,
// final_res on the last one. each result needs one pass of the shared
// 32-step divider. s_ready is high only while a row is being collected.
// the result sits in an output register; a stall on m_ready holds it and
// halts the element sequence until it is taken.
// epsilon (units 2^-16) is written through cfg_wr_en/cfg_wr_data; reset
// sets it to 1. the user writes it only while the block is idle: the block
// does not enforce this. aresetn is synchronous, active low: it empties the
// row and the output register, the element store is left as is.
module row_layer_normalizer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  rln_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output rln_pkg::out_item_t        m_data,
    input  logic                      cfg_wr_en,
    input  logic [rln_pkg::EPS_W-1:0] cfg_wr_data
);

    import rln_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rln_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .row_end (s_data.row_end),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rln_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.vdiv_start || cmd.ediv_start) |-> !sts.div_busy)
        else $error("divider started while busy");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.count <= CNT_W'(ROW_CAPACITY))
        else $error("element count beyond capacity");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result word overwritten before it was taken");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.row_clr |=> s_ready && sts.count == '0)
        else $error("row state not cleared after last result");

endmodule

[sv/rln_ram.sv]
module rln_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/rln_div.sv]
module rln_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rln_pkg::NUM_W-1:0] num,
    input  logic [rln_pkg::DEN_W-1:0] den,
    output logic                      busy,
    output logic                      done,
    output logic [rln_pkg::Q_W-1:0]   quot
);

    import rln_pkg::*;

    localparam int STEP_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0]    quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // quotient fits Q_W bits, so the upper numerator bits start below den
    assign trial = {rem_reg, quo_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == STEP_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_W'(num[NUM_W-1:Q_W]);
            quo_reg <= num[Q_W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

[sv/rln_ctrl.sv]
module rln_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          row_end,
    output logic          s_ready,
    input  rln_pkg::sts_t sts,
    output rln_pkg::cmd_t cmd
);

    import rln_pkg::*;

    localparam int DRAIN_W = $clog2(DRAIN_CYCLES);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;
    logic               idx_last;

    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) == sts.count;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_LOAD: begin
                idx_next = '0;
                if (s_valid && row_end) begin
                    state_next = ST_SSQ;
                end
            end
            ST_SSQ: begin
                if (idx_last) begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + DRAIN_W'(1);
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    state_next = ST_VSTART;
                end
            end
            ST_VSTART:  state_next = ST_VWAIT;
            ST_VWAIT: begin
                if (sts.div_done) begin
                    state_next = ST_SQSTART;
                end
            end
            ST_SQSTART: state_next = ST_SQWAIT;
            ST_SQWAIT: begin
                if (sts.sqrt_done) begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN: begin
                idx_next   = '0;
                state_next = ST_E_RD;
            end
            ST_E_RD:  state_next = ST_E_D;
            ST_E_D:   state_next = ST_E_DIV;
            ST_E_DIV: state_next = ST_E_WAIT;
            ST_E_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_E_MUL;
                end
            end
            ST_E_MUL: state_next = ST_E_OUT;
            ST_E_OUT: begin
                if (sts.out_free) begin
                    if (idx_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = ST_E_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.rd_addr = idx_reg;
        cmd.last    = idx_last;
        s_ready     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready     = 1'b1;
                cmd.load    = s_valid;
                cmd.acc_clr = 1'b1;
            end
            ST_SSQ:     cmd.ss_rd      = 1'b1;
            ST_VSTART:  cmd.vdiv_start = 1'b1;
            ST_VWAIT:   cmd.v_load     = sts.div_done;
            ST_SQSTART: cmd.sqrt_start = 1'b1;
            ST_DEN:     cmd.den_load   = 1'b1;
            ST_E_RD:    cmd.el_rd      = 1'b1;
            ST_E_D:     cmd.d_load     = 1'b1;
            ST_E_DIV:   cmd.ediv_start = 1'b1;
            ST_E_MUL:   cmd.prod_load  = 1'b1;
            ST_E_OUT: begin
                cmd.out_load = sts.out_free;
                cmd.row_clr  = sts.out_free && idx_last;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            idx_reg   <= '0;
            drain_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            drain_reg <= drain_next;
        end
    end

endmodule

[sv/rln_datapath.sv]
module rln_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rln_pkg::in_item_t         s_data,
    input  logic                      cfg_wr_en,
    input  logic [rln_pkg::EPS_W-1:0] cfg_wr_data,
    input  rln_pkg::cmd_t             cmd,
    output rln_pkg::sts_t             sts,
    output logic                      m_valid,
    input  logic                      m_ready,
    output rln_pkg::out_item_t        m_data
);

    import rln_pkg::*;

    localparam int SQR_REM_W = R_W + 2;
    localparam int SQR_STEP_W = $clog2(R_W + 1);
    localparam logic signed [Y_W-1:0] Y_HI = Y_W'(Y_MAX);
    localparam logic signed [Y_W-1:0] Y_LO = Y_W'(Y_MIN);

    logic [EPS_W-1:0]         eps_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     ovf_reg;
    logic                     room;

    logic [RAM_W-1:0]         rdata;
    logic signed [DATA_W-1:0] rd_sample, rd_scale, rd_shift;

    logic [2*CNT_W-1:0]       nsq_reg;
    logic [N3_W-1:0]          n3_reg;
    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [D_W-1:0]    d_calc, d_reg;
    logic [SQP_W-1:0]         sqp_reg;
    logic [SQ_W-1:0]          acc_reg;

    logic [V_W-1:0]           v_reg;
    logic [OP_W-1:0]          op_reg;
    logic [SQR_REM_W-1:0]     srem_reg;
    logic [R_W-1:0]           root_reg;
    logic [SQR_STEP_W-1:0]    scnt_reg;
    logic                     sbusy_reg, sdone_reg;
    logic [SQR_REM_W+1:0]     s_t, s_trial;
    logic                     s_ge;

    logic [DEN_W-1:0]         den_reg;
    logic [D_W-1:0]           abs_d;
    logic [NUM_W-1:0]         v_num, el_num, div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_start, div_busy, div_done;
    logic [Q_W-1:0]           quot;
    logic signed [XH_W-1:0]   xh;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_y;
    logic signed [Y_W-1:0]    y;
    out_item_t                out_reg;
    logic                     out_valid_reg;

    // element store: sample, scale, shift side by side
    rln_ram #(.WIDTH(RAM_W), .DEPTH(ROW_CAPACITY)) u_store (
        .aclk  (aclk),
        .we    (cmd.load && room),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({s_data.sample, s_data.scale, s_data.shift}),
        .re    (cmd.ss_rd || cmd.el_rd),
        .raddr (cmd.rd_addr),
        .rdata (rdata)
    );

    assign rd_sample = rdata[3*DATA_W-1:2*DATA_W];
    assign rd_scale  = rdata[2*DATA_W-1:DATA_W];
    assign rd_shift  = rdata[DATA_W-1:0];
    assign room      = count_reg < CNT_W'(ROW_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg   <= EPS_RESET;
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                eps_reg <= cfg_wr_data;
            end
            if (cmd.row_clr) begin
                count_reg <= '0;
                sum_reg   <= '0;
                ovf_reg   <= 1'b0;
            end else if (cmd.load) begin
                if (room) begin
                    count_reg <= count_reg + CNT_W'(1);
                    sum_reg   <= sum_reg + SUM_W'(s_data.sample);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // d = n*x - sum, exact centring without a division
    assign d_calc = D_W'($signed({1'b0, count_reg}) * rd_sample) - D_W'(sum_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.ss_rd;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        nsq_reg <= count_reg * count_reg;
        n3_reg  <= nsq_reg * count_reg;
        if (v1_reg || cmd.d_load) begin
            d_reg <= d_calc;
        end
        sqp_reg <= SQP_W'(d_reg * d_reg);
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (v3_reg) begin
            acc_reg <= acc_reg + SQ_W'(sqp_reg);
        end
        if (cmd.v_load) begin
            v_reg <= quot + V_W'(eps_reg);
        end
        if (cmd.den_load) begin
            den_reg <= count_reg * root_reg;
        end
        if (cmd.prod_load) begin
            prod_reg <= rd_scale * xh;
        end
    end

    // digit-by-digit square root of v * 2^30, two operand bits a step
    assign s_t     = {srem_reg, op_reg[OP_W-1:OP_W-2]};
    assign s_trial = (SQR_REM_W + 2)'({root_reg, 2'b01});
    assign s_ge    = s_t >= s_trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sbusy_reg <= 1'b0;
            sdone_reg <= 1'b0;
            scnt_reg  <= '0;
        end else begin
            sdone_reg <= sbusy_reg && (scnt_reg == SQR_STEP_W'(1));
            if (cmd.sqrt_start) begin
                sbusy_reg <= 1'b1;
                scnt_reg  <= SQR_STEP_W'(R_W);
            end else if (sbusy_reg) begin
                scnt_reg <= scnt_reg - SQR_STEP_W'(1);
                if (scnt_reg == SQR_STEP_W'(1)) begin
                    sbusy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            op_reg   <= {v_reg, V_SHIFT'(0)};
            srem_reg <= '0;
            root_reg <= '0;
        end else if (sbusy_reg) begin
            op_reg   <= {op_reg[OP_W-3:0], 2'b00};
            srem_reg <= s_ge ? SQR_REM_W'(s_t - s_trial) : SQR_REM_W'(s_t);
            root_reg <= {root_reg[R_W-2:0], s_ge};
        end
    end

    // shared divider: variance once per row, then one quotient per element
    assign abs_d    = d_reg[D_W-1] ? D_W'(-d_reg) : D_W'(d_reg);
    assign v_num    = NUM_W'(acc_reg) + NUM_W'(n3_reg >> 1);
    assign el_num   = (NUM_W'(abs_d) << XH_SHIFT) + NUM_W'(den_reg >> 1);
    assign div_num  = cmd.vdiv_start ? v_num : el_num;
    assign div_den  = cmd.vdiv_start ? DEN_W'(n3_reg) : den_reg;
    assign div_start = cmd.vdiv_start || cmd.ediv_start;

    rln_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (quot)
    );

    // zero root means zero variance and zero epsilon: x_hat is zero
    always_comb begin
        if (den_reg == '0) begin
            xh = '0;
        end else if (d_reg[D_W-1]) begin
            xh = -$signed({1'b0, quot[XH_W-2:0]});
        end else begin
            xh = $signed({1'b0, quot[XH_W-2:0]});
        end
    end

    assign acc_y = ACC_W'(prod_reg) + (ACC_W'(rd_shift) <<< FRAC_W)
                 + ACC_W'(ROUND_HALF);
    assign y     = acc_y[ACC_W-1:FRAC_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.truncated <= ovf_reg;
            out_reg.final_res <= cmd.last;
            if (y > Y_HI) begin
                out_reg.normalized <= DATA_W'(Y_MAX);
                out_reg.saturated  <= 1'b1;
            end else if (y < Y_LO) begin
                out_reg.normalized <= DATA_W'(Y_MIN);
                out_reg.saturated  <= 1'b1;
            end else begin
                out_reg.normalized <= y[DATA_W-1:0];
                out_reg.saturated  <= 1'b0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_data        = out_reg;
    assign sts.count     = count_reg;
    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;
    assign sts.sqrt_done = sdone_reg;
    assign sts.out_free  = !out_valid_reg || m_ready;

endmodule

[tb/sv/row_layer_normalizer_tb.sv]
`timescale 1ns / 100ps

module row_layer_normalizer_tb;
    import rln_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_data;
    logic                cfg_wr_en = 1'b0;
    logic [EPS_W-1:0]    cfg_wr_data = '0;

    in_item_t            pending_words[$];
    out_item_t           expected_results[$];
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  mismatches = 0;

    // predictor copy of the row state and epsilon
    logic signed [15:0]  row_sample[ROW_CAPACITY];
    logic signed [15:0]  row_scale[ROW_CAPACITY];
    logic signed [15:0]  row_shift[ROW_CAPACITY];
    int                  row_count = 0;
    longint              row_sum = 0;
    bit                  row_dropped = 1'b0;
    logic [EPS_W-1:0]    eps_model = EPS_RESET;

    row_layer_normalizer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // take one accepted word into the row, normalise the row on row_end
    task automatic absorb_word(input in_item_t w);
        longint          n;
        longint          d;
        longint          xh;
        longint          acc;
        longint          y;
        longint unsigned sq;
        longint unsigned n3;
        longint unsigned v;
        longint unsigned r;
        longint unsigned den;
        longint unsigned q;
        out_item_t       res;
        if (row_count < ROW_CAPACITY) begin
            row_sample[row_count] = w.sample;
            row_scale[row_count]  = w.scale;
            row_shift[row_count]  = w.shift;
            row_sum = row_sum + longint'(w.sample);
            row_count++;
        end else begin
            row_dropped = 1'b1;
        end
        if (!w.row_end) return;
        n = row_count;
        sq = 0;
        for (int i = 0; i < n; i++) begin
            d = n * longint'(row_sample[i]) - row_sum;
            if (d < 0) d = -d;
            sq = sq + longint'(d) * longint'(d);
        end
        n3 = n * n * n;
        v = (n3 != 0 ? (sq + n3 / 2) / n3 : 0) + eps_model;
        r = int_sqrt(v << 30);
        for (int i = 0; i < n; i++) begin
            d = n * longint'(row_sample[i]) - row_sum;
            xh = 0;
            if (r != 0 && d != 0) begin
                den = n * r;
                q = ((d < 0 ? -d : d) << 31);
                q = (q + den / 2) / den;
                xh = d < 0 ? -longint'(q) : longint'(q);
            end
            acc = longint'(row_scale[i]) * xh + longint'(row_shift[i]) * 65536 + 32768;
            y = acc >>> 16;
            res.saturated = 1'b0;
            if (y > Y_MAX) begin
                y = Y_MAX;
                res.saturated = 1'b1;
            end
            if (y < Y_MIN) begin
                y = Y_MIN;
                res.saturated = 1'b1;
            end
            res.normalized = y[15:0];
            res.truncated  = row_dropped;
            res.final_res  = (i + 1 == n);
            expected_results.push_back(res);
        end
        row_count = 0;
        row_sum = 0;
        row_dropped = 1'b0;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) absorb_word(s_data);
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word %p", m_data);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.normalized !== want.normalized) begin
                    $error("normalized: expected %0d, got %0d",
                           want.normalized, m_data.normalized);
                    mismatches++;
                end
                if (m_data.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b", want.saturated, m_data.saturated);
                    mismatches++;
                end
                if (m_data.truncated !== want.truncated) begin
                    $error("truncated: expected %0b, got %0b", want.truncated, m_data.truncated);
                    mismatches++;
                end
                if (m_data.final_res !== want.final_res) begin
                    $error("final_res: expected %0b, got %0b", want.final_res, m_data.final_res);
                    mismatches++;
                end
            end
        end
    end

    function automatic logic [15:0] rand_value(input bit narrow);
        if (narrow) return 16'($urandom_range(1024)) - 16'd512;
        return 16'($urandom);
    endfunction

    task automatic queue_word(input logic [15:0] x, input logic [15:0] g,
                              input logic [15:0] o, input bit last);
        in_item_t w;
        w.sample  = x;
        w.scale   = g;
        w.shift   = o;
        w.row_end = last;
        pending_words.push_back(w);
    endtask

    task automatic queue_random_row(input int len);
        bit narrow;
        narrow = $urandom_range(1);
        for (int i = 0; i < len; i++)
            queue_word(rand_value(narrow), rand_value(narrow), rand_value(narrow), i == len - 1);
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES + 8) @(posedge aclk);
    endtask

    task automatic write_epsilon(input logic [EPS_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        eps_model = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_phase(input int words, input int snd, input int rcv);
        int queued;
        int len;
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        queued = 0;
        while (queued < words) begin
            case ($urandom_range(19))
                0:       len = ROW_CAPACITY;
                1:       len = ROW_CAPACITY + $urandom_range(1, 6);
                default: len = $urandom_range(1, 8);
            endcase
            queue_random_row(len);
            queued += len;
        end
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows at reset epsilon
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_word(16'h1234, 16'h0100, 16'h0040, 1'b1);          // single element row
        queue_word(16'h8000, 16'h7fff, 16'h7fff, 1'b0);          // extremes, saturating
        queue_word(16'h7fff, 16'h8000, 16'h8000, 1'b1);
        queue_word(16'h7fff, 16'h7fff, 16'h8000, 1'b0);
        queue_word(16'h8000, 16'h8000, 16'h7fff, 1'b0);
        queue_word(16'h0000, 16'hffff, 16'h0000, 1'b1);
        for (int i = 0; i < 4; i++)
            queue_word(16'(i * 256), 16'h0100, 16'h0000, i == 3);
        queue_word(16'h0200, 16'h0100, 16'h0010, 1'b0);          // flat row
        queue_word(16'h0200, 16'h0100, 16'h0010, 1'b1);
        wait_idle();

        // zero variance with zero epsilon
        write_epsilon(16'h0000);
        for (int i = 0; i < 3; i++)
            queue_word(16'hff00, 16'h7fff, 16'(-100 + i), i == 2);
        queue_word(16'h0001, 16'h0100, 16'h0000, 1'b0);
        queue_word(16'h0000, 16'h0100, 16'h0000, 1'b1);
        random_phase(100, 31, 82);

        write_epsilon(16'hffff);
        random_phase(100, 82, 31);

        write_epsilon(16'($urandom));
        random_phase(110, 0, 0);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
